// ===== src/plss_pkg.sv =====
package plss_pkg;

    localparam int VALUE_W     = 32;
    localparam int GAP_W       = 16;
    localparam int COUNT_W     = 6;
    localparam int INDEX_W     = 6;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int TICK_W      = 23;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Shared restoring divider: two quotient bits per cycle.
    localparam int DIV_W        = 48;
    localparam int TIME_W       = 24;
    localparam int DIV_RADIX    = 2;
    localparam int DIV_T_CYCLES = TIME_W / DIV_RADIX;
    localparam int DIV_P_CYCLES = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_LOADED   = 3'd1,
        ST_STARTED  = 3'd2,
        ST_SETPOINT = 3'd3,
        ST_FINISHED = 3'd4,
        ST_REJECTED = 3'd5
    } st_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAP_MS      = 1'b0,
        CFG_POINT_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RD_LAST = 2'd0,
        RD_LOW  = 2'd1,
        RD_HIGH = 2'd2
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV1,
        S_RD_LAST,
        S_GET_LAST,
        S_RD_LOW,
        S_RD_HIGH,
        S_DIFF,
        S_MUL,
        S_PLOAD,
        S_DIV2,
        S_SUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     load_wr;
        logic     start_wr;
        logic     tick_adv;
        logic     stop;
        logic     div_load_t;
        logic     div_load_p;
        logic     div_step;
        rd_sel_t  rd_sel;
        logic     latch_a;
        logic     latch_last;
        logic     diff_en;
        logic     mul_en;
        logic     sum_en;
        logic     code_en;
        st_code_t code;
        logic     emit;
    } plss_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              idx_ok;
        logic              start_ok;
        logic              running;
        logic              past_end;
        logic              gap_zero;
        logic              div_done;
        logic              low_ge_last;
        logic              out_free;
    } plss_stat_t;

endpackage

// ===== src/plss_if.sv =====
interface plss_in_if;
    logic                                valid;
    logic                                ready;
    logic [plss_pkg::MODE_W-1:0]         mode;
    logic [plss_pkg::INDEX_W-1:0]        index;
    logic signed [plss_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink (input valid, input mode, input index, input value, output ready);
endinterface

interface plss_out_if;
    logic                                valid;
    logic                                ready;
    logic [plss_pkg::STATUS_W-1:0]       status;
    logic signed [plss_pkg::VALUE_W-1:0] setpoint;

    modport source (output valid, output status, output setpoint, input ready);
    modport sink (input valid, input status, input setpoint, output ready);
endinterface

// ===== src/plss_ctrl.sv =====
module plss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  plss_pkg::plss_stat_t stat,
    output plss_pkg::plss_cmd_t  cmd
);

    plss_pkg::state_t state_reg;
    plss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plss_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plss_pkg::S_DECODE;
                end
            end
            plss_pkg::S_DECODE:
            begin
                if (stat.mode == plss_pkg::MODE_TICK && stat.running && !stat.past_end)
                begin
                    if (stat.gap_zero)
                    begin
                        state_next = plss_pkg::S_RD_LAST;
                    end
                    else
                    begin
                        state_next = plss_pkg::S_DIV1;
                    end
                end
                else
                begin
                    state_next = plss_pkg::S_EMIT;
                end
            end
            plss_pkg::S_DIV1:
            begin
                if (stat.div_done)
                begin
                    if (stat.low_ge_last)
                    begin
                        state_next = plss_pkg::S_RD_LAST;
                    end
                    else
                    begin
                        state_next = plss_pkg::S_RD_LOW;
                    end
                end
            end
            plss_pkg::S_RD_LAST:  state_next = plss_pkg::S_GET_LAST;
            plss_pkg::S_GET_LAST: state_next = plss_pkg::S_EMIT;
            plss_pkg::S_RD_LOW:   state_next = plss_pkg::S_RD_HIGH;
            plss_pkg::S_RD_HIGH:  state_next = plss_pkg::S_DIFF;
            plss_pkg::S_DIFF:     state_next = plss_pkg::S_MUL;
            plss_pkg::S_MUL:      state_next = plss_pkg::S_PLOAD;
            plss_pkg::S_PLOAD:    state_next = plss_pkg::S_DIV2;
            plss_pkg::S_DIV2:
            begin
                if (stat.div_done)
                begin
                    state_next = plss_pkg::S_SUM;
                end
            end
            plss_pkg::S_SUM:      state_next = plss_pkg::S_EMIT;
            plss_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = plss_pkg::S_IDLE;
                end
            end
            default:              state_next = plss_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            plss_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            plss_pkg::S_DECODE:
            begin
                cmd.code_en = 1'b1;
                cmd.code    = plss_pkg::ST_IDLE;
                priority if (stat.mode == plss_pkg::MODE_LOAD)
                begin
                    cmd.load_wr = stat.idx_ok;
                    cmd.code    = stat.idx_ok ? plss_pkg::ST_LOADED : plss_pkg::ST_REJECTED;
                end
                else if (stat.mode == plss_pkg::MODE_START)
                begin
                    cmd.start_wr = stat.start_ok;
                    cmd.code     = stat.start_ok ? plss_pkg::ST_STARTED
                                                 : plss_pkg::ST_REJECTED;
                end
                else if (stat.mode == plss_pkg::MODE_TICK && stat.running)
                begin
                    cmd.tick_adv = 1'b1;
                    if (stat.past_end)
                    begin
                        cmd.stop = 1'b1;
                        cmd.code = plss_pkg::ST_FINISHED;
                    end
                    else
                    begin
                        cmd.code_en    = 1'b0;
                        cmd.div_load_t = !stat.gap_zero;
                    end
                end
                else
                begin
                    // idle tick or unused mode: answer idle, touch nothing
                    cmd.code = plss_pkg::ST_IDLE;
                end
            end
            plss_pkg::S_DIV1:     cmd.div_step = !stat.div_done;
            plss_pkg::S_RD_LAST:  cmd.rd_sel = plss_pkg::RD_LAST;
            plss_pkg::S_GET_LAST:
            begin
                cmd.latch_last = 1'b1;
                cmd.code_en    = 1'b1;
                cmd.code       = plss_pkg::ST_SETPOINT;
            end
            plss_pkg::S_RD_LOW:   cmd.rd_sel = plss_pkg::RD_LOW;
            plss_pkg::S_RD_HIGH:
            begin
                cmd.rd_sel  = plss_pkg::RD_HIGH;
                cmd.latch_a = 1'b1;
            end
            plss_pkg::S_DIFF:     cmd.diff_en = 1'b1;
            plss_pkg::S_MUL:      cmd.mul_en = 1'b1;
            plss_pkg::S_PLOAD:    cmd.div_load_p = 1'b1;
            plss_pkg::S_DIV2:     cmd.div_step = !stat.div_done;
            plss_pkg::S_SUM:
            begin
                cmd.sum_en  = 1'b1;
                cmd.code_en = 1'b1;
                cmd.code    = plss_pkg::ST_SETPOINT;
            end
            plss_pkg::S_EMIT:     cmd.emit = stat.out_free;
            default:              cmd = '0;
        endcase
    end

endmodule

// ===== src/plss_dpath.sv =====
module plss_dpath #(
    parameter int MAX_POINTS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [plss_pkg::MODE_W-1:0]           in_mode,
    input  logic [plss_pkg::INDEX_W-1:0]          in_index,
    input  logic signed [plss_pkg::VALUE_W-1:0]   in_value,
    input  logic                                  cfg_we,
    input  logic [plss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [plss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [plss_pkg::STATUS_W-1:0]         out_status,
    output logic signed [plss_pkg::VALUE_W-1:0]   out_setpoint,
    input  plss_pkg::plss_cmd_t                   cmd,
    output plss_pkg::plss_stat_t                  stat
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int VW  = plss_pkg::VALUE_W;
    localparam int GW  = plss_pkg::GAP_W;
    localparam int CW  = plss_pkg::COUNT_W;
    localparam int TW  = plss_pkg::TICK_W;
    localparam int DW  = plss_pkg::DIV_W;
    localparam int EW  = CW + GW;

    // configuration
    logic [GW-1:0] gap_reg;
    logic [CW-1:0] pc_reg;

    // captured word
    logic [plss_pkg::MODE_W-1:0]  mode_reg;
    logic [plss_pkg::INDEX_W-1:0] index_reg;
    logic [VW-1:0]                value_reg;

    // sequence state
    logic          running_reg;
    logic [TW-1:0] tc_reg;
    logic [TW-1:0] end_reg;

    // table
    logic [VW-1:0] mem [MAX_POINTS];
    logic [VW-1:0] rdata_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          mem_we;

    // arithmetic
    logic [VW-1:0]              a_reg;
    logic [VW:0]                diff_reg;
    logic signed [DW:0]         prod_reg;
    logic                       neg_reg;
    logic [VW-1:0]              sp_reg;
    plss_pkg::st_code_t         code_reg;
    logic [DW-1:0]              div_num_reg;
    logic [GW-1:0]              div_rem_reg;
    logic [plss_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [DW-1:0]              div_num_step;
    logic [GW-1:0]              div_rem_step;

    // output register
    logic                         out_valid_reg;
    logic [plss_pkg::STATUS_W-1:0] out_status_reg;
    logic [VW-1:0]                out_sp_reg;

    logic [CW-1:0]                pc_sat;
    logic [CW-1:0]                last_cnt;
    logic [AW-1:0]                last_idx;
    logic [AW-1:0]                low_idx;
    logic [TW-1:0]                tc_inc;
    logic [plss_pkg::TIME_W-1:0]  t_val;
    logic [EW-1:0]                end_prod;
    logic signed [DW+1:0]         prod_full;
    logic [DW:0]                  prod_neg;
    logic [DW-1:0]                prod_mag;
    logic [VW:0]                  q_ext;
    logic [VW:0]                  q_signed;
    logic [VW:0]                  sum_full;

    always_comb
    begin
        pc_sat   = (pc_reg > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_reg;
        last_cnt = (pc_sat == '0) ? '0 : pc_sat - CW'(1);
        last_idx = AW'(last_cnt);
        low_idx  = div_num_reg[AW-1:0];
        tc_inc   = tc_reg + TW'(1);
        t_val    = {1'b0, tc_inc} + plss_pkg::TIME_W'(1);
        end_prod = EW'(pc_reg - CW'(1)) * EW'(gap_reg);
        prod_full = $signed(diff_reg) * $signed({1'b0, div_rem_reg});
        prod_neg  = -prod_reg;
        prod_mag  = prod_reg[DW] ? prod_neg[DW-1:0] : prod_reg[DW-1:0];
        q_ext     = {1'b0, div_num_reg[VW-1:0]};
        q_signed  = neg_reg ? -q_ext : q_ext;
        sum_full  = {a_reg[VW-1], a_reg} + q_signed;
    end

    always_comb
    begin
        stat.mode        = mode_reg;
        stat.idx_ok      = {1'b0, index_reg} < (plss_pkg::INDEX_W + 1)'(MAX_POINTS);
        stat.start_ok    = (pc_reg >= CW'(2)) && (pc_reg <= CW'(MAX_POINTS))
                           && (gap_reg != '0);
        stat.running     = running_reg;
        stat.past_end    = tc_inc > end_reg;
        stat.gap_zero    = (gap_reg == '0);
        stat.div_done    = (div_cnt_reg == '0);
        stat.low_ge_last = div_num_reg[plss_pkg::TIME_W-1:0]
                           >= plss_pkg::TIME_W'(last_idx);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GW'(1);
            pc_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (plss_pkg::cfg_idx_t'(cfg_index))
                plss_pkg::CFG_GAP_MS:      gap_reg <= cfg_data[GW-1:0];
                plss_pkg::CFG_POINT_COUNT: pc_reg <= cfg_data[CW-1:0];
                default:                   gap_reg <= gap_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            tc_reg      <= '0;
            end_reg     <= '0;
        end
        else
        begin
            if (cmd.start_wr)
            begin
                running_reg <= 1'b1;
                tc_reg      <= '0;
                end_reg     <= TW'(end_prod);
            end
            else
            begin
                if (cmd.tick_adv)
                begin
                    tc_reg <= tc_inc;
                end
                if (cmd.stop)
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

    // breakpoint table, one write and one registered read port
    assign mem_we  = cmd.load_wr || cmd.start_wr;
    assign wr_addr = cmd.start_wr ? '0 : index_reg[AW-1:0];

    always_comb
    begin
        unique case (cmd.rd_sel)
            plss_pkg::RD_LAST: rd_addr = last_idx;
            plss_pkg::RD_LOW:  rd_addr = low_idx;
            plss_pkg::RD_HIGH: rd_addr = low_idx + AW'(1);
            default:           rd_addr = last_idx;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    // two restoring steps per cycle; quotient shifts in from the bottom
    always_comb
    begin
        logic [GW:0]   trial;
        logic [GW-1:0] r;
        logic [DW-1:0] n;
        r = div_rem_reg;
        n = div_num_reg;
        for (int i = 0; i < plss_pkg::DIV_RADIX; i++)
        begin
            trial = {r, n[DW-1]};
            n     = {n[DW-2:0], 1'b0};
            if (trial >= {1'b0, gap_reg})
            begin
                trial = trial - {1'b0, gap_reg};
                n[0]  = 1'b1;
            end
            r = trial[GW-1:0];
        end
        div_rem_step = r;
        div_num_step = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_load_t)
        begin
            div_cnt_reg <= plss_pkg::DIV_CNT_W'(plss_pkg::DIV_T_CYCLES);
        end
        else if (cmd.div_load_p)
        begin
            div_cnt_reg <= plss_pkg::DIV_CNT_W'(plss_pkg::DIV_P_CYCLES);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - plss_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load_t)
        begin
            div_num_reg <= {t_val, {(DW - plss_pkg::TIME_W){1'b0}}};
            div_rem_reg <= '0;
        end
        else if (cmd.div_load_p)
        begin
            div_num_reg <= prod_mag;
            div_rem_reg <= '0;
            neg_reg     <= prod_reg[DW];
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= div_num_step;
            div_rem_reg <= div_rem_step;
        end
        if (cmd.latch_a)
        begin
            a_reg <= rdata_reg;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= {rdata_reg[VW-1], rdata_reg} - {a_reg[VW-1], a_reg};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_full[DW:0];
        end
        if (cmd.latch_last)
        begin
            sp_reg <= rdata_reg;
        end
        else if (cmd.sum_en)
        begin
            sp_reg <= sum_full[VW-1:0];
        end
        if (cmd.code_en)
        begin
            code_reg <= cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= code_reg;
            out_sp_reg     <= (code_reg == plss_pkg::ST_SETPOINT) ? sp_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_setpoint = out_sp_reg;

endmodule

// ===== src/piecewise_linear_setpoint_sequencer.sv =====
// Setpoint trajectory generator over a table of evenly spaced Q16.16 breakpoints.
// Words enter on in_ch (mode, index, value) and each one yields exactly one word
// on out_ch (status, setpoint). Mode load writes a breakpoint, mode start checks
// point_count and gap_ms, seeds breakpoint 0 with the valve position and arms
// the tick counter, mode tick returns the next interpolated setpoint or the
// finish word. Registers gap_ms (index 0) and point_count (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no word
// is in flight, as the block does not enforce it. One word is in work at a time.
// Load, start, idle and finish words go from decode straight to the output load,
// after which the next word is taken. A tick between breakpoints passes decode,
// the shared two-bit-per-cycle divider to locate the segment, the fetch of the
// points and the scaling of their difference, the divider again for the quotient,
// then the sum and the output load. A tick that clamps to the last point runs the
// divider and then reads that point, or skips the divider when gap_ms is zero.
// Reset clears the sequence state, sets gap_ms to 1 and point_count to 0; the
// breakpoint table is not cleared and must be loaded before use.
// The result sits in an output register; the block takes the next word while it
// waits, and holds the following result until the receiver drains out_ch.
module piecewise_linear_setpoint_sequencer #(
    parameter int MAX_POINTS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    plss_in_if.sink                               in_ch,
    plss_out_if.source                            out_ch,
    input  logic                                  cfg_we,
    input  logic [plss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [plss_pkg::CFG_DATA_W-1:0]       cfg_data
);

    plss_pkg::plss_cmd_t  cmd;
    plss_pkg::plss_stat_t stat;

    // sequencer: decodes the captured word and steps the datapath
    plss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, counters, divider, multiplier and output register
    plss_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mode      (in_ch.mode),
        .in_index     (in_ch.index),
        .in_value     (in_ch.value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_status   (out_ch.status),
        .out_setpoint (out_ch.setpoint),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== sim/plss_setpoint_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the sequencer, predicts every result word and
// compares it with what the block delivers.
module plss_setpoint_checker
    import plss_pkg::*;
#(
    parameter int MAX_POINTS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    plss_in_if                     in_ch,
    plss_out_if                    out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_total,
    output int                     pending_words
);

    typedef struct packed {
        st_code_t                  status;
        logic signed [VALUE_W-1:0] setpoint;
    } sp_word_t;

    logic signed [VALUE_W-1:0] breakpoints [MAX_POINTS];
    logic [TICK_W-1:0]         ticks;
    logic [TICK_W-1:0]         end_tick;
    logic                      seq_running;
    logic [GAP_W-1:0]          gap_ms;
    logic [COUNT_W-1:0]        pt_count;
    sp_word_t                  expected_words [$];

    // Setpoint at tick t: clamp past the last point, else interpolate inside
    // the segment with the quotient truncated toward zero.
    function automatic logic signed [VALUE_W-1:0] interpolate_setpoint(int unsigned t);
        int unsigned n;
        int unsigned last;
        int unsigned seg;
        int unsigned frac;
        longint      a;
        longint      b;
        longint      q;
        n = (pt_count > MAX_POINTS) ? MAX_POINTS : pt_count;
        last = (n > 0) ? n - 1 : 0;
        if (gap_ms == 0)
            return breakpoints[last];
        seg = t / gap_ms;
        if (seg >= last)
            return breakpoints[last];
        frac = t - seg * gap_ms;
        a = breakpoints[seg];
        b = breakpoints[seg + 1];
        q = ((b - a) * longint'(frac)) / longint'(gap_ms);
        return VALUE_W'(a + q);
    endfunction

    function automatic sp_word_t advance_sequencer(logic [MODE_W-1:0] mode,
                                                   logic [INDEX_W-1:0] idx,
                                                   logic signed [VALUE_W-1:0] val);
        sp_word_t w;
        w.status = ST_IDLE;
        w.setpoint = '0;
        case (mode)
            MODE_LOAD:
            begin
                if (idx < MAX_POINTS)
                begin
                    breakpoints[idx] = val;
                    w.status = ST_LOADED;
                end
                else
                    w.status = ST_REJECTED;
            end
            MODE_START:
            begin
                if (pt_count < 2 || pt_count > MAX_POINTS || gap_ms == 0)
                    w.status = ST_REJECTED;
                else
                begin
                    breakpoints[0] = val;
                    ticks = '0;
                    end_tick = TICK_W'((int'(pt_count) - 1) * int'(gap_ms));
                    seq_running = 1'b1;
                    w.status = ST_STARTED;
                end
            end
            MODE_TICK:
            begin
                if (seq_running)
                begin
                    ticks = ticks + 1'b1;
                    if (ticks > end_tick)
                    begin
                        seq_running = 1'b0;
                        w.status = ST_FINISHED;
                    end
                    else
                    begin
                        w.setpoint = interpolate_setpoint(32'(ticks) + 1);
                        w.status = ST_SETPOINT;
                    end
                end
            end
            default:
                ;
        endcase
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sp_word_t want;
        int       errs;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < MAX_POINTS; i++)
                breakpoints[i] = '0;
            ticks = '0;
            end_tick = '0;
            seq_running = 1'b0;
            gap_ms = GAP_W'(1);
            pt_count = '0;
            expected_words.delete();
            mismatch_total <= 0;
            pending_words <= 0;
        end
        else
        begin
            errs = 0;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatch_total + errs < 10)
                        $display("%0t: word with nothing expected, status %0d setpoint %h",
                                 $time, out_ch.status, out_ch.setpoint);
                    errs++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        if (mismatch_total + errs < 10)
                            $display("%0t: status expected %0d, got %0d",
                                     $time, want.status, out_ch.status);
                        errs++;
                    end
                    if (out_ch.setpoint !== want.setpoint)
                    begin
                        if (mismatch_total + errs < 10)
                            $display("%0t: setpoint expected %h, got %h",
                                     $time, want.setpoint, out_ch.setpoint);
                        errs++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_GAP_MS)
                    gap_ms = cfg_data[GAP_W-1:0];
                else
                    pt_count = cfg_data[COUNT_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(advance_sequencer(in_ch.mode, in_ch.index,
                                                           in_ch.value));
            mismatch_total <= mismatch_total + errs;
            pending_words <= expected_words.size();
        end
    end

endmodule

// ===== sim/tb_piecewise_linear_setpoint_sequencer.sv =====
`timescale 1ns / 100ps

module tb_piecewise_linear_setpoint_sequencer;

    import plss_pkg::*;

    localparam int MAX_POINTS   = 20;
    localparam int RANDOM_WORDS = 400;
    // Longest sequence we let run before moving on to the next setting.
    localparam int TICK_CAP     = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Drain time after the last word: a full interpolating tick plus margin.
    localparam int TAIL_CYCLES  = 64;
    // Mode code the block has no use for; it must answer like an idle tick.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_total;
    int pending_words;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_idle_pct;
    int stim_words;

    // Stimulus-side view of the configuration and of which table entries hold
    // data; entry 0 is always seeded by a start before any tick can read it.
    logic [GAP_W-1:0]   cur_gap;
    logic [COUNT_W-1:0] cur_count;
    bit                 point_loaded [MAX_POINTS];

    plss_in_if  in_ch ();
    plss_out_if out_ch ();

    piecewise_linear_setpoint_sequencer #(
        .MAX_POINTS (MAX_POINTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plss_setpoint_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) u_setpoint_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatch_total),
        .pending_words  (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: drop ready at random according to the current idle share.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: end the run at CYCLE_LIMIT, in case the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Q16.16 values biased toward the extremes, zero and small magnitudes so
    // that both the sign bit and the fraction bits see every value.
    function automatic logic signed [VALUE_W-1:0] random_q16();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return 32'($urandom_range(0, 131072)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GAP_W-1:0] pick_gap();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAP_W'($urandom_range(7, 400));
            4, 5:    return GAP_W'(1);
            default: return GAP_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0:       return COUNT_W'($urandom_range(0, 1));
            1:       return COUNT_W'($urandom_range(MAX_POINTS + 1, 2**COUNT_W - 1));
            2:       return COUNT_W'(MAX_POINTS);
            3:       return COUNT_W'(2);
            default: return COUNT_W'($urandom_range(2, 6));
        endcase
    endfunction

    // Present one word and hold it until the block takes it. Valid is left
    // high so that a following word goes out back to back.
    task automatic send_word(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                             logic signed [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.index <= idx;
        in_ch.value <= val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (mode == MODE_LOAD && idx < MAX_POINTS)
            point_loaded[idx] = 1'b1;
        if (mode != MODE_SPARE)
            stim_words++;
    endtask

    // Lower valid and wait until every word in flight has come back. The
    // first edge lets the checker record a word accepted at this very edge.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // Write both registers while the block is idle, then fill every table entry from 1
    // up that the new count could make a tick read and that holds no data yet.
    task automatic set_config(logic [GAP_W-1:0] gap, logic [COUNT_W-1:0] count);
        int n;
        int i;
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_GAP_MS;
        cfg_data <= gap;
        @(posedge clk);
        // Upper data bits are junk; the register keeps only its own width.
        cfg_index <= CFG_POINT_COUNT;
        cfg_data <= {10'($urandom), count};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_gap = gap;
        cur_count = count;
        n = (count > MAX_POINTS) ? MAX_POINTS : count;
        for (i = 1; i < n; i++)
            if (!point_loaded[i])
                send_word(MODE_LOAD, INDEX_W'(i), random_q16());
    endtask

    // Occasionally slip in a word off the main path: the spare mode, a load
    // outside the table, a load into the live table, a restart or a stray tick.
    task automatic random_noise();
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 4))
                0: send_word(MODE_SPARE, INDEX_W'($urandom), $urandom);
                1: send_word(MODE_LOAD, INDEX_W'($urandom_range(MAX_POINTS, 2**INDEX_W - 1)),
                             random_q16());
                2: send_word(MODE_LOAD, INDEX_W'($urandom_range(0, MAX_POINTS - 1)),
                             random_q16());
                3: send_word(MODE_START, INDEX_W'($urandom), random_q16());
                default: send_word(MODE_TICK, INDEX_W'($urandom), $urandom);
            endcase
        end
    endtask

    // One well-formed sequence: refresh a few breakpoints, start from a random
    // valve position, then tick through to the finish word (capped for slow
    // profiles, which are left running into the next setting).
    task automatic run_sequence();
        int span;
        int n_ticks;
        repeat ($urandom_range(0, 3))
            send_word(MODE_LOAD, INDEX_W'($urandom_range(0, MAX_POINTS - 1)), random_q16());
        random_noise();
        send_word(MODE_START, INDEX_W'($urandom), random_q16());
        if (cur_count >= 2 && cur_count <= MAX_POINTS && cur_gap != 0)
        begin
            span = (int'(cur_count) - 1) * int'(cur_gap) + 1 + $urandom_range(0, 2);
            n_ticks = (span > TICK_CAP) ? TICK_CAP : span;
        end
        else
            n_ticks = $urandom_range(3, 10);
        repeat (n_ticks)
        begin
            random_noise();
            send_word(MODE_TICK, INDEX_W'($urandom), $urandom);
        end
    endtask

    initial
    begin : stimulus
        // Drive every input to a known value and hold reset.
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_GAP_MS;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_TICK;
        in_ch.index <= '0;
        in_ch.value <= '0;
        cur_gap = GAP_W'(1);
        cur_count = '0;
        stim_words = 0;
        foreach (point_loaded[i])
            point_loaded[i] = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 88;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Idle tick, spare mode, a start with no points and
        // loads just past and far past the table.
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_SPARE, '1, 32'sh7FFF_FFFF);
        send_word(MODE_START, '0, '0);
        send_word(MODE_LOAD, INDEX_W'(MAX_POINTS), 32'sh1234_5678);
        send_word(MODE_LOAD, '1, 32'sh8000_0000);

        // Zero gap must reject the start.
        set_config('0, COUNT_W'(2));
        send_word(MODE_START, '0, 32'sh0001_0000);

        // Full-scale swing between neighbors: position at the top, point 1 at
        // the bottom, so the difference needs all 33 bits.
        set_config(GAP_W'(2), COUNT_W'(3));
        send_word(MODE_LOAD, INDEX_W'(1), 32'sh8000_0000);
        send_word(MODE_LOAD, INDEX_W'(2), 32'sh7FFF_FFFF);
        send_word(MODE_LOAD, INDEX_W'(MAX_POINTS - 1), 32'shFFFF_FFFF);
        send_word(MODE_START, '0, 32'sh7FFF_FFFF);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        // Rewrite a point the running profile has yet to reach.
        send_word(MODE_LOAD, INDEX_W'(2), 32'sh0000_8000);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);

        // Restart while running.
        send_word(MODE_START, INDEX_W'(42), 32'sh8000_0000);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_START, INDEX_W'(21), 32'sh0000_0001);
        send_word(MODE_TICK, '0, '0);

        // Change registers under a live profile: zero gap holds the last
        // point, an oversized count saturates to the table size.
        set_config('0, COUNT_W'(3));
        send_word(MODE_TICK, '0, '0);
        set_config(GAP_W'(1), '1);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);

        // Random part in three idling regimes: sender mostly busy with a
        // sluggish receiver, then the reverse, then no idling at all.
        stim_words = 0;
        while (stim_words < RANDOM_WORDS)
        begin
            if (stim_words >= 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (stim_words >= RANDOM_WORDS / 3)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 21;
            end
            set_config(pick_gap(), pick_count());
            run_sequence();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && pending_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
